### rtl/core/chc_pkg.sv
// ----------------------------------------------------------------------------
// chc_pkg: shared types and constants for the cartridge header checker
// Header address map, result record and ROM size code decode.
// ----------------------------------------------------------------------------
package chc_pkg;

	localparam int unsigned ADDR_W = 16;

	// Header address map
	localparam logic [ADDR_W-1:0] TITLE_FIRST = 16'h0134;
	localparam logic [ADDR_W-1:0] TITLE_LAST  = 16'h0143;
	localparam logic [ADDR_W-1:0] MAKER_GUARD = 16'h013E;
	localparam logic [ADDR_W-1:0] MAKER_FIRST = 16'h013F;
	localparam logic [ADDR_W-1:0] MAKER_LAST  = 16'h0142;
	localparam logic [ADDR_W-1:0] HSUM_FIRST  = 16'h0134;
	localparam logic [ADDR_W-1:0] HSUM_LAST   = 16'h014C;
	localparam logic [ADDR_W-1:0] HSUM_ADDR   = 16'h014D;
	localparam logic [ADDR_W-1:0] GSUM_HI     = 16'h014E;
	localparam logic [ADDR_W-1:0] GSUM_LO     = 16'h014F;
	localparam logic [ADDR_W-1:0] CODES_FIRST = 16'h0146;
	localparam logic [ADDR_W-1:0] CODES_LAST  = 16'h014B;
	localparam logic [ADDR_W-1:0] CODES_BASE  = 16'h0145;

	localparam logic [7:0] HIGH_BIT_MASK = 8'h80;

	// ROM size codes outside the power-of-two range
	localparam logic [7:0] ROM_CODE_72 = 8'h52;
	localparam logic [7:0] ROM_CODE_80 = 8'h53;
	localparam logic [7:0] ROM_CODE_96 = 8'h54;
	localparam logic [7:0] ROM_CODE_POW_MAX = 8'h07;

	// 16384-byte banks
	localparam int unsigned BANK_SHIFT = 14;
	localparam int unsigned BANKS_W = 9;
	localparam int unsigned EXPECT_W = BANKS_W + BANK_SHIFT;

	// Captured header bytes: 0x143, then 0x146..0x14B
	localparam int unsigned HDR_BYTES = 7;
	localparam int unsigned HDR_IDX_W = 3;
	localparam logic [HDR_IDX_W-1:0] HDR_COLOR   = 3'd0;
	localparam logic [HDR_IDX_W-1:0] HDR_SUPER   = 3'd1;
	localparam logic [HDR_IDX_W-1:0] HDR_KIND    = 3'd2;
	localparam logic [HDR_IDX_W-1:0] HDR_ROM     = 3'd3;
	localparam logic [HDR_IDX_W-1:0] HDR_RAM     = 3'd4;
	localparam logic [HDR_IDX_W-1:0] HDR_REGION  = 3'd5;
	localparam logic [HDR_IDX_W-1:0] HDR_LICENSE = 3'd6;

	typedef logic [7:0] hdr_bytes_t [HDR_BYTES];

	typedef struct packed {
		logic       size_ok;
		logic       header_ok;
		logic       global_ok;
		logic [4:0] title_length;
		logic [2:0] maker_length;
		logic [7:0] color_flag;
		logic [7:0] super_flag;
		logic [7:0] cart_kind;
		logic [7:0] rom_size_code;
		logic [7:0] ram_size_code;
		logic [7:0] region_code;
		logic [7:0] licensee_code;
	} chc_result_t;

	// Bank count for a ROM size code; zero for unknown codes
	function automatic logic [BANKS_W-1:0] banks_of(input logic [7:0] code);
		logic [BANKS_W-1:0] banks;
		banks = '0;
		if (code <= ROM_CODE_POW_MAX) begin
			banks = BANKS_W'(2) << code[2:0];
		end else if (code == ROM_CODE_72) begin
			banks = BANKS_W'(72);
		end else if (code == ROM_CODE_80) begin
			banks = BANKS_W'(80);
		end else if (code == ROM_CODE_96) begin
			banks = BANKS_W'(96);
		end
		return banks;
	endfunction

endpackage

### rtl/core/chc_image_if.sv
// ----------------------------------------------------------------------------
// chc_image_if: image byte channel
// One image byte per beat with an end-of-image marker.
// ----------------------------------------------------------------------------
interface chc_image_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, output data_byte, output last, input ready);
	modport sink (input valid, input data_byte, input last, output ready);
endinterface

### rtl/core/chc_result_if.sv
// ----------------------------------------------------------------------------
// chc_result_if: header report channel
// One report beat per image: verdicts and decoded header codes.
// ----------------------------------------------------------------------------
interface chc_result_if;
	logic       valid;
	logic       ready;
	logic       size_ok;
	logic       header_ok;
	logic       global_ok;
	logic [4:0] title_length;
	logic [2:0] maker_length;
	logic [7:0] color_flag;
	logic [7:0] super_flag;
	logic [7:0] cart_kind;
	logic [7:0] rom_size_code;
	logic [7:0] ram_size_code;
	logic [7:0] region_code;
	logic [7:0] licensee_code;

	modport source (
		output valid, input ready,
		output size_ok, output header_ok, output global_ok,
		output title_length, output maker_length,
		output color_flag, output super_flag, output cart_kind,
		output rom_size_code, output ram_size_code,
		output region_code, output licensee_code
	);
	modport sink (
		input valid, output ready,
		input size_ok, input header_ok, input global_ok,
		input title_length, input maker_length,
		input color_flag, input super_flag, input cart_kind,
		input rom_size_code, input ram_size_code,
		input region_code, input licensee_code
	);
endinterface

### rtl/core/chc_accum.sv
// ----------------------------------------------------------------------------
// chc_accum: per-image running state
// Address counter, checksums, length counters and header byte capture.
// Report fields come from the updated state; state clears after a last beat.
// ----------------------------------------------------------------------------
module chc_accum #(
	parameter int unsigned COUNTER_BITS = 23
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           data_byte,
	input  logic                 last,
	output chc_pkg::chc_result_t res
);
	import chc_pkg::*;

	localparam int unsigned CMP_W = (COUNTER_BITS + 1 > EXPECT_W) ? COUNTER_BITS + 1 : EXPECT_W;
	localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

	logic [COUNTER_BITS-1:0] addr_q, addr_n;
	logic [7:0]  head_sum_q, head_sum_n;
	logic [15:0] whole_sum_q, whole_sum_n;
	logic [7:0]  st_head_q, st_head_n;
	logic [15:0] st_whole_q, st_whole_n;
	logic [4:0]  title_cnt_q, title_cnt_n;
	logic        title_stop_q, title_stop_n;
	logic [2:0]  maker_cnt_q, maker_cnt_n;
	logic        maker_stop_q, maker_stop_n;
	hdr_bytes_t  hdr_q, hdr_n;

	logic                saturated;
	logic [ADDR_W-1:0]   addr_lo;
	logic                addr_hi_zero;
	logic [BANKS_W-1:0]  banks;
	logic [CMP_W-1:0]    expect_len;
	logic [CMP_W-1:0]    seen_len;

	// Header addresses all fit in 16 bits; upper bits must be clear to match
	assign addr_lo      = addr_q[ADDR_W-1:0];
	assign addr_hi_zero = (COUNTER_BITS == ADDR_W) ? 1'b1
		: ((addr_q >> ADDR_W) == '0);
	assign saturated    = (addr_q == CNT_MAX);

	always_comb begin
		addr_n       = saturated ? addr_q : addr_q + COUNTER_BITS'(1);
		head_sum_n   = head_sum_q;
		whole_sum_n  = whole_sum_q;
		st_head_n    = st_head_q;
		st_whole_n   = st_whole_q;
		title_cnt_n  = title_cnt_q;
		title_stop_n = title_stop_q;
		maker_cnt_n  = maker_cnt_q;
		maker_stop_n = maker_stop_q;
		hdr_n        = hdr_q;

		if (addr_hi_zero && addr_lo >= TITLE_FIRST && addr_lo <= TITLE_LAST) begin
			if (data_byte == 8'h00 || (data_byte & HIGH_BIT_MASK) != 8'h00) begin
				title_stop_n = 1'b1;
			end else if (!title_stop_q) begin
				title_cnt_n = title_cnt_q + 5'd1;
			end
		end
		if (addr_hi_zero && addr_lo == MAKER_GUARD && data_byte != 8'h00) begin
			maker_stop_n = 1'b1;
		end
		if (addr_hi_zero && addr_lo >= MAKER_FIRST && addr_lo <= MAKER_LAST) begin
			if (data_byte == 8'h00) begin
				maker_stop_n = 1'b1;
			end else if (!maker_stop_q) begin
				maker_cnt_n = maker_cnt_q + 3'd1;
			end
		end
		if (addr_hi_zero && addr_lo >= HSUM_FIRST && addr_lo <= HSUM_LAST) begin
			head_sum_n = head_sum_q - data_byte - 8'd1;
		end
		if (addr_hi_zero && addr_lo == HSUM_ADDR) begin
			st_head_n = data_byte;
		end
		if (addr_hi_zero && addr_lo == GSUM_HI) begin
			st_whole_n = {data_byte, st_whole_q[7:0]};
		end else if (addr_hi_zero && addr_lo == GSUM_LO) begin
			st_whole_n = {st_whole_q[15:8], data_byte};
		end else begin
			whole_sum_n = whole_sum_q + {8'h00, data_byte};
		end
		if (addr_hi_zero && addr_lo == TITLE_LAST) begin
			hdr_n[HDR_COLOR] = data_byte;
		end else if (addr_hi_zero && addr_lo >= CODES_FIRST && addr_lo <= CODES_LAST) begin
			hdr_n[HDR_IDX_W'(addr_lo - CODES_BASE)] = data_byte;
		end
	end

	// Size check: image length against bank count of the ROM code
	assign banks      = banks_of(hdr_n[HDR_ROM]);
	assign expect_len = CMP_W'({banks, BANK_SHIFT'(0)});
	assign seen_len   = CMP_W'(addr_q) + CMP_W'(1);

	always_comb begin
		res.size_ok       = !saturated && (banks != '0) && (seen_len == expect_len);
		res.header_ok     = (head_sum_n == st_head_n);
		res.global_ok     = (whole_sum_n == st_whole_n);
		res.title_length  = title_cnt_n;
		res.maker_length  = maker_cnt_n;
		res.color_flag    = hdr_n[HDR_COLOR];
		res.super_flag    = hdr_n[HDR_SUPER];
		res.cart_kind     = hdr_n[HDR_KIND];
		res.rom_size_code = hdr_n[HDR_ROM];
		res.ram_size_code = hdr_n[HDR_RAM];
		res.region_code   = hdr_n[HDR_REGION];
		res.licensee_code = hdr_n[HDR_LICENSE];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q       <= '0;
			head_sum_q   <= '0;
			whole_sum_q  <= '0;
			st_head_q    <= '0;
			st_whole_q   <= '0;
			title_cnt_q  <= '0;
			title_stop_q <= 1'b0;
			maker_cnt_q  <= '0;
			maker_stop_q <= 1'b0;
			for (int i = 0; i < HDR_BYTES; i++) begin
				hdr_q[i] <= '0;
			end
		end else if (step) begin
			if (last) begin
				addr_q       <= '0;
				head_sum_q   <= '0;
				whole_sum_q  <= '0;
				st_head_q    <= '0;
				st_whole_q   <= '0;
				title_cnt_q  <= '0;
				title_stop_q <= 1'b0;
				maker_cnt_q  <= '0;
				maker_stop_q <= 1'b0;
				for (int i = 0; i < HDR_BYTES; i++) begin
					hdr_q[i] <= '0;
				end
			end else begin
				addr_q       <= addr_n;
				head_sum_q   <= head_sum_n;
				whole_sum_q  <= whole_sum_n;
				st_head_q    <= st_head_n;
				st_whole_q   <= st_whole_n;
				title_cnt_q  <= title_cnt_n;
				title_stop_q <= title_stop_n;
				maker_cnt_q  <= maker_cnt_n;
				maker_stop_q <= maker_stop_n;
				hdr_q        <= hdr_n;
			end
		end
	end

endmodule

### rtl/core/chc_result_reg.sv
// ----------------------------------------------------------------------------
// chc_result_reg: report output register
// Holds one report beat until the sink takes it.
// ----------------------------------------------------------------------------
module chc_result_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  chc_pkg::chc_result_t res_d,
	output logic                 busy,
	chc_result_if.source         report
);
	import chc_pkg::*;

	logic        valid_q;
	chc_result_t res_q;

	// Held and not taken this cycle: a new load would overwrite it
	assign busy = valid_q && !report.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (report.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_d;
		end
	end

	assign report.valid         = valid_q;
	assign report.size_ok       = res_q.size_ok;
	assign report.header_ok     = res_q.header_ok;
	assign report.global_ok     = res_q.global_ok;
	assign report.title_length  = res_q.title_length;
	assign report.maker_length  = res_q.maker_length;
	assign report.color_flag    = res_q.color_flag;
	assign report.super_flag    = res_q.super_flag;
	assign report.cart_kind     = res_q.cart_kind;
	assign report.rom_size_code = res_q.rom_size_code;
	assign report.ram_size_code = res_q.ram_size_code;
	assign report.region_code   = res_q.region_code;
	assign report.licensee_code = res_q.licensee_code;

endmodule

### rtl/core/cartridge_header_checker_top.sv
// ----------------------------------------------------------------------------
// cartridge_header_checker_top: cartridge header checker
// Streams a cartridge image and reports header/global checksum verdicts,
// image size verdict, title/maker lengths and header codes.
// ----------------------------------------------------------------------------
//
//   channel   dir   beat contents                           per image
//   -------   ---   -------------------------------------   ---------
//   image     in    data_byte[7:0], last                    N beats
//   report    out   verdicts, lengths, seven header codes   1 beat
//
// One image byte per cycle sustained while stage 1 is not stalled. A beat is
// registered in stage 1 and then folded into the running state; on the last
// beat the report lands in the output register, which drives report valid.
// Stage 1 stalls only while it holds a last beat and the previous report is
// still held by the sink; non-last beats never wait on the sink.
// Reset clears all running state; after every last beat the state clears
// again, so the next beat is address zero of a new image.
//
module cartridge_header_checker_top #(
	parameter int unsigned COUNTER_BITS = 23
) (
	input logic          clk,
	input logic          arst_n,
	chc_image_if.sink    image,
	chc_result_if.source report
);
	import chc_pkg::*;

	// Stage 1: input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	logic        out_busy;
	logic        advance;
	logic        step;
	chc_result_t res;

	// A last beat needs room in the output register; others never wait
	assign advance     = !(last_s1 && out_busy);
	assign step        = valid_s1 && advance;
	assign image.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (image.ready) begin
			valid_s1 <= image.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (image.valid && image.ready) begin
			byte_s1 <= image.data_byte;
			last_s1 <= image.last;
		end
	end

	// Running checksums, counters and header capture
	chc_accum #(
		.COUNTER_BITS(COUNTER_BITS)
	) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data_byte (byte_s1),
		.last      (last_s1),
		.res       (res)
	);

	// Report register toward the sink
	chc_result_reg u_result (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (step && last_s1),
		.res_d  (res),
		.busy   (out_busy),
		.report (report)
	);

	// A processed last beat always yields a report next cycle
	a_last_gives_report: assert property (@(posedge clk) disable iff (!arst_n)
		(step && last_s1) |=> report.valid)
		else $error("last beat did not produce a report");

	// A pending last beat never overwrites a held report
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1 && out_busy) |-> (!step && !image.ready))
		else $error("last beat advanced over a held report");

	// Empty stage 1 always takes a beat
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> image.ready)
		else $error("stage 1 empty but not ready");

	// Length counters stay within header field sizes
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		report.valid |-> (report.title_length <= 5'd16 && report.maker_length <= 3'd4))
		else $error("length out of range");

endmodule
